/* rtl/u2u8_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// UTF-16 to UTF-8 transcoder package
// Shared job record, widths and surrogate range constants.
// ---------------------------------------------------------------------------
package u2u8_pkg;

  localparam int unsigned UnitW    = 16;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned MaxBytes = 6;
  localparam int unsigned CntW     = 3;

  localparam logic [UnitW-1:0] HighFirst = 16'hD800;
  localparam logic [UnitW-1:0] HighLast  = 16'hDBFF;
  localparam logic [UnitW-1:0] LowFirst  = 16'hDC00;
  localparam logic [UnitW-1:0] LowLast   = 16'hDFFF;
  localparam logic [UnitW-1:0] OneByteLimit = 16'h0080;
  localparam logic [UnitW-1:0] TwoByteLimit = 16'h0800;
  localparam logic [20:0]      SuppBase  = 21'h10000;

  localparam logic [ByteW-1:0] Lead2Tag  = 8'hC0;
  localparam logic [ByteW-1:0] Lead3Tag  = 8'hE0;
  localparam logic [ByteW-1:0] Lead4Tag  = 8'hF0;
  localparam logic [ByteW-1:0] ContTag   = 8'h80;

  // Each accepted unit turns into at most one job: up to six bytes plus the end flag.
  // A job with no bytes is a bare end marker.
  typedef struct packed {
    logic [MaxBytes-1:0][ByteW-1:0] bytes;
    logic [CntW-1:0]                cnt;
    logic                           last;
  } job_t;

endpackage : u2u8_pkg
`default_nettype wire

/* rtl/u2u8_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Transcoder front end
// Accepts code units, pairs surrogates and builds the byte job for each unit.
// ---------------------------------------------------------------------------
module u2u8_front
  import u2u8_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [UnitW-1:0] unit_i,
  input  wire logic             last_i,
  input  wire logic             q_full_i,
  output logic                  push_o,
  output job_t                  job_o
);

  logic       pend_q, pend_d;
  logic [9:0] held_q, held_d;
  logic       accept;
  logic       is_high, is_low, pair;
  logic [20:0] cp;
  logic [2:0][ByteW-1:0] q_bytes;
  logic [CntW-1:0]       q_cnt;
  logic                  hold_new;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  assign is_high = (unit_i >= HighFirst) && (unit_i <= HighLast);
  assign is_low  = (unit_i >= LowFirst) && (unit_i <= LowLast);
  assign pair    = pend_q && is_low;
  assign cp      = SuppBase + {1'b0, held_q, unit_i[9:0]};

  // Bytes that the new unit gives on its own.
  always_comb begin
    q_bytes  = '0;
    q_cnt    = '0;
    hold_new = 1'b0;
    if (last_i && (unit_i == '0)) begin
      q_cnt = '0;
    end else if (unit_i < OneByteLimit) begin
      q_bytes[0] = unit_i[7:0];
      q_cnt      = CntW'(1);
    end else if (unit_i < TwoByteLimit) begin
      q_bytes[0] = Lead2Tag | {3'b000, unit_i[10:6]};
      q_bytes[1] = ContTag | {2'b00, unit_i[5:0]};
      q_cnt      = CntW'(2);
    end else if (is_high && !last_i) begin
      hold_new = 1'b1;
    end else begin
      q_bytes[0] = Lead3Tag | {4'h0, unit_i[15:12]};
      q_bytes[1] = ContTag | {2'b00, unit_i[11:6]};
      q_bytes[2] = ContTag | {2'b00, unit_i[5:0]};
      q_cnt      = CntW'(3);
    end
  end

  always_comb begin
    job_o       = '0;
    job_o.last  = last_i;
    pend_d      = pend_q;
    held_d      = held_q;
    if (pair) begin
      job_o.bytes[0] = Lead4Tag | {5'b00000, cp[20:18]};
      job_o.bytes[1] = ContTag | {2'b00, cp[17:12]};
      job_o.bytes[2] = ContTag | {2'b00, cp[11:6]};
      job_o.bytes[3] = ContTag | {2'b00, cp[5:0]};
      job_o.cnt      = CntW'(4);
    end else if (pend_q) begin
      // A lone high surrogate goes out as three bytes ahead of the new unit.
      job_o.bytes[0] = Lead3Tag | {4'h0, HighFirst[15:12]};
      job_o.bytes[1] = ContTag | {2'b00, HighFirst[11:10], held_q[9:6]};
      job_o.bytes[2] = ContTag | {2'b00, held_q[5:0]};
      job_o.bytes[3] = q_bytes[0];
      job_o.bytes[4] = q_bytes[1];
      job_o.bytes[5] = q_bytes[2];
      job_o.cnt      = CntW'(3) + q_cnt;
    end else begin
      job_o.bytes[0] = q_bytes[0];
      job_o.bytes[1] = q_bytes[1];
      job_o.bytes[2] = q_bytes[2];
      job_o.cnt      = q_cnt;
    end
    if (accept) begin
      pend_d = !pair && hold_new;
      held_d = (!pair && hold_new) ? unit_i[9:0] : '0;
    end
  end

  // A held high surrogate with no end flag produces nothing yet.
  assign push_o = accept && ((job_o.cnt != '0) || last_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
      held_q <= '0;
    end else begin
      pend_q <= pend_d;
      held_q <= held_d;
    end
  end

endmodule : u2u8_front
`default_nettype wire

/* rtl/u2u8_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Job queue
// Small register queue between the front end and the byte emitter.
// ---------------------------------------------------------------------------
module u2u8_fifo
  import u2u8_pkg::*;
#(
  parameter int unsigned Depth = 2
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  job_t      push_job_i,
  input  wire logic pop_i,
  output job_t      head_o,
  output logic      full_o,
  output logic      empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntFW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  job_t             mem_q [Depth];
  logic [PtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CntFW-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntFW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == LastPtr) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == LastPtr) ? '0 : rd_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntFW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntFW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule : u2u8_fifo
`default_nettype wire

/* rtl/u2u8_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Byte emitter
// Walks the job at the head of the queue and sends one byte per transfer.
// ---------------------------------------------------------------------------
module u2u8_back
  import u2u8_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  job_t                  head_i,
  input  wire logic             empty_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [ByteW-1:0]      out_byte_o,
  output logic                  byte_valid_o,
  output logic                  last_byte_o
);

  logic [CntW-1:0]  idx_q, idx_d;
  logic             vld_q, vld_d;
  logic [ByteW-1:0] byte_q, byte_d;
  logic             bval_q, bval_d;
  logic             last_q, last_d;
  logic             load, marker, final_byte;

  // The output register takes a new byte whenever the queue holds a job and the register is empty or drained.
  assign load       = !empty_i && (!vld_q || out_ready_i);
  assign marker     = (head_i.cnt == '0);
  assign final_byte = marker || (idx_q == (head_i.cnt - CntW'(1)));
  assign pop_o      = load && final_byte;

  always_comb begin
    idx_d  = idx_q;
    vld_d  = vld_q;
    byte_d = byte_q;
    bval_d = bval_q;
    last_d = last_q;
    if (load) begin
      vld_d  = 1'b1;
      byte_d = marker ? '0 : head_i.bytes[idx_q];
      bval_d = !marker;
      last_d = head_i.last && final_byte;
      idx_d  = final_byte ? '0 : idx_q + CntW'(1);
    end else if (out_ready_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      vld_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    bval_q <= bval_d;
    last_q <= last_d;
  end

  assign out_valid_o  = vld_q;
  assign out_byte_o   = byte_q;
  assign byte_valid_o = bval_q;
  assign last_byte_o  = last_q;

endmodule : u2u8_back
`default_nettype wire

/* rtl/utf16_to_utf8_transcoder.sv */
// The first byte of a unit passes the job queue and then the output register
// before it reaches the output.
// Throughput: one output byte per cycle while the queue holds a job and the sink
// is ready. The emitter stays on a job until all of its bytes are sent, and the
// front end keeps taking units until the job queue between them is full.
// Reset (rst_ni low, asynchronous) empties the queue and drops any held surrogate.
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// UTF-16 to UTF-8 transcoder
// Converts a stream of UTF-16 code units into UTF-8 bytes, lone surrogates
// encoded as three bytes.
// ---------------------------------------------------------------------------
module utf16_to_utf8_transcoder
  import u2u8_pkg::*;
#(
  parameter int unsigned QueueDepth = 2
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [15:0] s_axis_tdata_i,   // [15:0] code_unit
  input  wire logic        s_axis_tlast_i,   // last_unit
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [7:0]       m_axis_tdata_o,   // [7:0] out_byte
  output logic             m_axis_tuser_o,   // [0] byte_valid
  output logic             m_axis_tlast_o    // last_byte
);

  job_t front_job, head_job;
  logic push, pop, q_full, q_empty;

  u2u8_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .unit_i     (s_axis_tdata_i),
    .last_i     (s_axis_tlast_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .job_o      (front_job)
  );

  u2u8_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (front_job),
    .pop_i      (pop),
    .head_o     (head_job),
    .full_o     (q_full),
    .empty_o    (q_empty)
  );

  u2u8_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head_job),
    .empty_i      (q_empty),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_byte_o   (m_axis_tdata_o),
    .byte_valid_o (m_axis_tuser_o),
    .last_byte_o  (m_axis_tlast_o)
  );

endmodule : utf16_to_utf8_transcoder
`default_nettype wire

/* rtl/u2u8_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Transcoder port checker
// Watches the output stream for framing and encoding rules.
// ---------------------------------------------------------------------------
module u2u8_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [7:0]  m_axis_tdata_o,
  input wire logic        m_axis_tuser_o,
  input wire logic        m_axis_tlast_o
);

  a_out_hold_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("output transfer withdrawn while stalled");

  a_out_hold_data : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o))
    else $error("output byte changed while stalled");

  // A bare end marker always closes the string and carries a zero byte.
  a_marker_is_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o |-> m_axis_tlast_o && (m_axis_tdata_o == 8'h00))
    else $error("end marker without end flag or with data");

  // A lead byte of a multi-byte sequence can never be the final byte.
  a_lead_not_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o && (m_axis_tdata_o[7:6] == 2'b11) |-> !m_axis_tlast_o)
    else $error("lead byte flagged as end of string");

  // Four-byte leads stay within the supplementary range.
  a_lead4_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o && (m_axis_tdata_o[7:3] == 5'b11110)
      |-> (m_axis_tdata_o[2:0] <= 3'd4))
    else $error("four-byte lead out of range");

endmodule : u2u8_checker

bind utf16_to_utf8_transcoder u2u8_checker u_u2u8_checker (.*);
`default_nettype wire
